@@ rtl/core/snd_pkg.sv @@
// ----------------------------------------------------------------------------
// snd_pkg
// Shared types and codes of the spike neighbor deduplication block.
// ----------------------------------------------------------------------------
package snd_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_FILTER = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_FILTER = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_WALK1,
      S_WALK2,
      S_DONE
   } state_type;

   localparam logic [7:0] CSR_NOISE_WINDOW  = 8'd0;
   localparam logic [7:0] CSR_KEEP_FRACTION = 8'd1;

   localparam int SLOT_W = 7;   // valid bit plus 6-bit channel

   typedef struct packed {
      logic [5:0]         channel;
      logic [31:0]        frame;
      logic signed [15:0] amplitude;
   } spike_type;

endpackage

@@ rtl/core/snd_spike_ram.sv @@
// ----------------------------------------------------------------------------
// snd_spike_ram
// Pending spike buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module snd_spike_ram #(
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  snd_pkg::spike_type         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output snd_pkg::spike_type         rd_data
);
   import snd_pkg::*;

   spike_type mem [DEPTH];
   spike_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/spike_neighbor_dedup.sv @@
// ----------------------------------------------------------------------------
// spike_neighbor_dedup
// Neighbor table plus ordered spike buffer with a two-pass dedup filter.
// ----------------------------------------------------------------------------
// Steps: a load reads the row, then merges one slot and writes it back; an
// append writes the buffer directly; a filter makes two passes over the
// buffered spikes (the RAM streams one entry a cycle).
// Throughput: one item at a time; the next item is taken once the result sits
// in the output register, even while that result is still stalled.
// Reset: synchronous; clears control, count and row valid bits (all neighbor
// slots read empty). No clearing pass; buffer contents stay undefined.
// ----------------------------------------------------------------------------
module spike_neighbor_dedup #(
   parameter int CHANNELS      = 64,
   parameter int ROW_SLOTS     = 8,
   parameter int BUFFER_DEPTH  = 64
) (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [5:0]         req_spike_channel,
   input  logic [31:0]        req_spike_frame,
   input  logic signed [15:0] req_spike_amplitude,
   input  logic [2:0]         req_slot_index,
   input  logic [5:0]         req_neighbor_value,
   input  logic               req_neighbor_used,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_winner_channel,
   output logic [31:0]        rsp_winner_frame,
   output logic signed [15:0] rsp_winner_amplitude,
   output logic [6:0]         rsp_pending_count,
   // configuration writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import snd_pkg::*;

   // Only rows reachable by a 6-bit channel are stored.
   localparam int ROWS    = (CHANNELS < 64) ? CHANNELS : 64;
   localparam int TW      = $clog2(ROWS);
   localparam int ROW_W   = ROW_SLOTS * SLOT_W;
   localparam int AW      = $clog2(BUFFER_DEPTH);
   localparam int CW      = $clog2(BUFFER_DEPTH + 1);
   localparam logic [6:0]    ROWS7  = 7'(ROWS);
   localparam logic [6:0]    SLOTS7 = 7'(ROW_SLOTS);
   localparam logic [CW-1:0] DEPTHC = CW'(BUFFER_DEPTH);

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [5:0]         ch_ff, ch_in;
   logic [2:0]         slot_ff, slot_in;
   logic [5:0]         nval_ff, nval_in;
   logic               nused_ff, nused_in;
   logic [32:0]        lim_ff, lim_in;
   logic [5:0]         mch_ff, mch_in;
   logic [31:0]        mfr_ff, mfr_in;
   logic signed [15:0] mamp_ff, mamp_in;
   status_type         st_ff, st_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic [CW-1:0]      w_ff, w_in;
   logic               pv_ff, pv_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [7:0]         nw_ff;
   logic [8:0]         kf_ff;
   logic               rowok_ff, rowok_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [5:0]         rsp_wch_ff, rsp_wch_in;
   logic [31:0]        rsp_wfr_ff, rsp_wfr_in;
   logic signed [15:0] rsp_wamp_ff, rsp_wamp_in;
   logic [6:0]         rsp_cnt_ff, rsp_cnt_in;

   // ------------------------------------------------------------------------
   // Neighbor table: one row of all slots per word, row valid in flops
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0] tbl_mem [ROWS];
   logic [ROW_W-1:0] tbl_rd_ff;
   logic [ROWS-1:0]  rowv_ff;
   logic             tbl_re;
   logic [5:0]       tbl_rch;
   logic             tbl_we;
   logic [ROW_W-1:0] tbl_wd;
   logic [ROW_W-1:0] nb_row;

   always_ff @(posedge clock) begin
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_rch[TW-1:0]];
      end
      if (tbl_we) begin
         tbl_mem[ch_ff[TW-1:0]] <= tbl_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rowv_ff <= '0;
      end else if (tbl_we) begin
         rowv_ff[ch_ff[TW-1:0]] <= 1'b1;
      end
   end

   // A row never loaded, or a channel without a row, reads all empty.
   assign nb_row = rowok_ff ? tbl_rd_ff : '0;

   // ------------------------------------------------------------------------
   // Spike buffer
   // ------------------------------------------------------------------------
   logic      buf_we;
   logic [AW-1:0] buf_wa;
   spike_type buf_wd;
   logic      buf_re;
   spike_type buf_rd;

   snd_spike_ram #(
      .DEPTH (BUFFER_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wa),
      .wr_data (buf_wd),
      .rd_en   (buf_re),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (buf_rd)
   );

   // ------------------------------------------------------------------------
   // Per-entry compare: neighbor hit, window, keep threshold
   // ------------------------------------------------------------------------
   logic               hit;
   logic               in_win;
   logic signed [25:0] lhs;
   logic signed [25:0] rhs;

   always_comb begin
      hit = 1'b0;
      for (int s = 0; s < ROW_SLOTS; s++) begin
         if (nb_row[s*SLOT_W + 6] && nb_row[s*SLOT_W +: 6] == buf_rd.channel) begin
            hit = 1'b1;
         end
      end
   end

   assign in_win = {1'b0, buf_rd.frame} <= lim_ff;
   assign lhs    = {{2{buf_rd.amplitude[15]}}, buf_rd.amplitude, 8'b0};
   assign rhs    = 26'(mamp_ff * $signed({1'b0, kf_ff}));

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nw_ff <= 8'd5;
         kf_ff <= 9'd128;
      end else if (csr_valid) begin
         if (csr_index == CSR_NOISE_WINDOW) begin
            nw_ff <= csr_wdata[7:0];
         end else if (csr_index == CSR_KEEP_FRACTION) begin
            kf_ff <= csr_wdata[8:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   logic issue;
   logic walk_done;

   assign issue     = rd_idx_ff != count_ff;
   assign walk_done = !issue && !pv_ff;
   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      slot_in   = slot_ff;
      nval_in   = nval_ff;
      nused_in  = nused_ff;
      lim_in    = lim_ff;
      mch_in    = mch_ff;
      mfr_in    = mfr_ff;
      mamp_in   = mamp_ff;
      st_in     = st_ff;
      rd_idx_in = rd_idx_ff;
      w_in      = w_ff;
      pv_in     = 1'b0;
      count_in  = count_ff;

      tbl_re    = 1'b0;
      tbl_rch   = req_spike_channel;
      tbl_we    = 1'b0;
      tbl_wd    = nb_row;
      buf_we    = 1'b0;
      buf_wa    = w_ff[AW-1:0];
      buf_wd    = buf_rd;
      buf_re    = 1'b0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_wch_in    = rsp_wch_ff;
      rsp_wfr_in    = rsp_wfr_ff;
      rsp_wamp_in   = rsp_wamp_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in    = req_spike_channel;
               slot_in  = req_slot_index;
               nval_in  = req_neighbor_value;
               nused_in = req_neighbor_used;
               tbl_re   = 1'b1;
               st_in    = STATUS_OK;
               state_in = S_DONE;
               unique case (req_kind)
                  KIND_LOAD: begin
                     state_in = S_LOAD;
                  end
                  KIND_APPEND: begin
                     if (count_ff < DEPTHC) begin
                        buf_we   = 1'b1;
                        buf_wa   = count_ff[AW-1:0];
                        buf_wd   = '{channel:   req_spike_channel,
                                     frame:     req_spike_frame,
                                     amplitude: req_spike_amplitude};
                        count_in = count_ff + CW'(1);
                     end else begin
                        st_in = STATUS_FULL;
                     end
                  end
                  KIND_FILTER: begin
                     mch_in    = req_spike_channel;
                     mfr_in    = req_spike_frame;
                     mamp_in   = req_spike_amplitude;
                     lim_in    = {1'b0, req_spike_frame} + 33'(nw_ff);
                     rd_idx_in = '0;
                     w_in      = '0;
                     state_in  = S_WALK1;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_LOAD: begin
            // merge the one slot into the row just read, write it back
            for (int s = 0; s < ROW_SLOTS; s++) begin
               if (7'(s) == 7'(slot_ff)) begin
                  tbl_wd[s*SLOT_W +: SLOT_W] = nused_ff ? {1'b1, nval_ff} : '0;
               end
            end
            tbl_we   = (7'(ch_ff) < ROWS7) && (7'(slot_ff) < SLOTS7);
            state_in = S_DONE;
         end

         S_WALK1: begin
            if (issue) begin
               buf_re    = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
               pv_in     = 1'b1;
            end
            if (pv_ff) begin
               // keep by default; merge neighbors inside the window, keep the others only at or above the keep fraction
               buf_we = 1'b1;
               if (hit) begin
                  if (in_win) begin
                     buf_we = 1'b0;
                     if (buf_rd.amplitude >= mamp_ff) begin
                        mch_in  = buf_rd.channel;
                        mfr_in  = buf_rd.frame;
                        mamp_in = buf_rd.amplitude;
                     end
                  end else begin
                     buf_we = lhs >= rhs;
                  end
               end
               if (buf_we) begin
                  w_in = w_ff + CW'(1);
               end
            end
            if (walk_done) begin
               // fetch the winner's row for the second pass
               count_in  = w_ff;
               tbl_re    = 1'b1;
               tbl_rch   = mch_ff;
               rd_idx_in = '0;
               w_in      = '0;
               state_in  = S_WALK2;
            end
         end

         S_WALK2: begin
            if (issue) begin
               buf_re    = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
               pv_in     = 1'b1;
            end
            if (pv_ff) begin
               // drop weaker neighbors of the winner
               buf_we = !(hit && (mamp_ff > buf_rd.amplitude));
               if (buf_we) begin
                  w_in = w_ff + CW'(1);
               end
            end
            if (walk_done) begin
               count_in = w_ff;
               st_in    = STATUS_FILTER;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_cnt_in    = 7'(count_ff);
               if (st_ff == STATUS_FILTER) begin
                  rsp_wch_in  = mch_ff;
                  rsp_wfr_in  = mfr_ff;
                  rsp_wamp_in = mamp_ff;
               end else begin
                  rsp_wch_in  = '0;
                  rsp_wfr_in  = '0;
                  rsp_wamp_in = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // row valid and range travel with the table read data
   assign rowok_in = tbl_re ? ((7'(tbl_rch) < ROWS7) && rowv_ff[tbl_rch[TW-1:0]])
                            : rowok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pv_ff        <= 1'b0;
         rd_idx_ff    <= '0;
         w_ff         <= '0;
         rowok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pv_ff        <= pv_in;
         rd_idx_ff    <= rd_idx_in;
         w_ff         <= w_in;
         rowok_ff     <= rowok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      slot_ff       <= slot_in;
      nval_ff       <= nval_in;
      nused_ff      <= nused_in;
      lim_ff        <= lim_in;
      mch_ff        <= mch_in;
      mfr_ff        <= mfr_in;
      mamp_ff       <= mamp_in;
      st_ff         <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_wch_ff    <= rsp_wch_in;
      rsp_wfr_ff    <= rsp_wfr_in;
      rsp_wamp_ff   <= rsp_wamp_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_winner_channel   = rsp_wch_ff;
   assign rsp_winner_frame     = rsp_wfr_ff;
   assign rsp_winner_amplitude = rsp_wamp_ff;
   assign rsp_pending_count    = rsp_cnt_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTHC)
      else $error("buffer count beyond depth");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK1 || state_ff == S_WALK2) |-> w_ff <= rd_idx_ff)
      else $error("compaction write ahead of read");

   a_pass_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK2 && $past(state_ff) == S_WALK1) |-> count_ff <= $past(count_ff))
      else $error("first pass grew the buffer");

   a_winner_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_FILTER) |->
         (rsp_winner_channel == '0 && rsp_winner_frame == '0 && rsp_winner_amplitude == '0))
      else $error("winner fields set on non-filter item");

endmodule

@@ tb/spike_neighbor_dedup_tb.sv @@
// ----------------------------------------------------------------------------
// spike_neighbor_dedup_tb
// Drives load, append and filter items into the spike dedup block, predicts
// every result from a local model of the neighbor table and spike buffer, and
// checks the results in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module spike_neighbor_dedup_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import snd_pkg::*;

   typedef struct {
      status_type         status;
      logic [5:0]         channel;
      logic [31:0]        frame;
      logic signed [15:0] amplitude;
      logic [6:0]         count;
   } outcome_type;

   // Scoreboard: local copy of table, buffer and registers plus expected queue.
   class dedup_scoreboard;
      bit          slot_used[64][8];
      bit [5:0]    slot_chan[64][8];
      spike_type   pending[$];
      bit [7:0]    window;
      bit [8:0]    fraction;
      outcome_type expected[$];
      int          errors;

      function new();
         window = 5;
         fraction = 128;
         errors = 0;
         foreach (slot_used[r, s]) slot_used[r][s] = 0;
      endfunction

      function bit neighbor_of(bit [5:0] row, bit [5:0] ch);
         for (int s = 0; s < 8; s++)
            if (slot_used[row][s] && slot_chan[row][s] == ch) return 1;
         return 0;
      endfunction

      // Apply one accepted item and queue its result.
      function void note_item(kind_type k, bit [5:0] ch, bit [31:0] fr,
                              logic signed [15:0] amp, bit [2:0] slot,
                              bit [5:0] nval, bit nused);
         outcome_type o;
         spike_type kept[$];
         spike_type m;
         bit [32:0] lim;
         longint lhs, rhs;
         bit keep;
         o = '{STATUS_OK, 0, 0, 0, 0};
         case (k)
            KIND_LOAD: begin
               slot_used[ch][slot] = nused;
               slot_chan[ch][slot] = nused ? nval : 6'd0;
            end
            KIND_APPEND: begin
               if (pending.size() < 64) pending.push_back('{ch, fr, amp});
               else o.status = STATUS_FULL;
            end
            KIND_FILTER: begin
               lim = {1'b0, fr} + window;
               m = '{ch, fr, amp};
               foreach (pending[i]) begin
                  keep = 1;
                  if (neighbor_of(ch, pending[i].channel)) begin
                     if ({1'b0, pending[i].frame} <= lim) begin
                        keep = 0;
                        if (pending[i].amplitude >= m.amplitude) m = pending[i];
                     end else begin
                        lhs = longint'(pending[i].amplitude) * 256;
                        rhs = longint'(m.amplitude) * longint'(fraction);
                        keep = lhs >= rhs;
                     end
                  end
                  if (keep) kept.push_back(pending[i]);
               end
               pending = {};
               foreach (kept[i])
                  if (!(neighbor_of(m.channel, kept[i].channel) &&
                        m.amplitude > kept[i].amplitude))
                     pending.push_back(kept[i]);
               o.status = STATUS_FILTER;
               o.channel = m.channel;
               o.frame = m.frame;
               o.amplitude = m.amplitude;
            end
            default: ;
         endcase
         o.count = 7'(pending.size());
         expected.push_back(o);
      endfunction

      function void check_result(logic [1:0] st, logic [5:0] ch, logic [31:0] fr,
                                 logic signed [15:0] amp, logic [6:0] cnt);
         outcome_type e;
         if (expected.size() == 0) begin
            $error("unexpected result, status %0d", st);
            errors++;
            return;
         end
         e = expected.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, st); errors++;
         end
         if (ch !== e.channel) begin
            $error("winner_channel: expected %0d actual %0d", e.channel, ch); errors++;
         end
         if (fr !== e.frame) begin
            $error("winner_frame: expected %0d actual %0d", e.frame, fr); errors++;
         end
         if (amp !== e.amplitude) begin
            $error("winner_amplitude: expected %0d actual %0d", e.amplitude, amp);
            errors++;
         end
         if (cnt !== e.count) begin
            $error("pending_count: expected %0d actual %0d", e.count, cnt); errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_kind = 0;
   logic [5:0]         req_spike_channel = 0;
   logic [31:0]        req_spike_frame = 0;
   logic signed [15:0] req_spike_amplitude = 0;
   logic [2:0]         req_slot_index = 0;
   logic [5:0]         req_neighbor_value = 0;
   logic               req_neighbor_used = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_winner_channel;
   logic [31:0]        rsp_winner_frame;
   logic signed [15:0] rsp_winner_amplitude;
   logic [6:0]         rsp_pending_count;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [7:0]         csr_index = 0;
   logic [15:0]        csr_wdata = 0;

   dedup_scoreboard board = new();
   bit   hold_off = 0;     // request for a long receiver stall
   int   idle_cycles = 0;
   localparam int WATCHDOG = 20000;
   localparam int HOLD_CYCLES = 400;

   spike_neighbor_dedup dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Check results and record accepted items at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_result(rsp_status, rsp_winner_channel, rsp_winner_frame,
                               rsp_winner_amplitude, rsp_pending_count);
         if (req_valid && !req_stall)
            board.note_item(kind_type'(req_kind), req_spike_channel, req_spike_frame,
                            req_spike_amplitude, req_slot_index, req_neighbor_value,
                            req_neighbor_used);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver stall pattern: quiet stretches, random stalls, or a long hold-off.
   initial begin
      int mode;
      int hold_left;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(20, 120)) begin
            if (hold_off) begin
               hold_off = 0;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               rsp_stall <= 1;
               hold_left--;
            end
            else if (mode == 0) rsp_stall <= 0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 1) == 0);
            @(posedge clock);
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock)
      if (idle_cycles >= WATCHDOG) begin
         $display("== FAIL ==");
         $finish;
      end

   int burst_left = 0;

   // Offer one item; hold it until accepted. Gaps come between bursts.
   task automatic send_item(kind_type k, bit [5:0] ch, bit [31:0] fr,
                            bit [15:0] amp, bit [2:0] slot, bit [5:0] nval,
                            bit nused);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_kind <= k;
      req_spike_channel <= ch;
      req_spike_frame <= fr;
      req_spike_amplitude <= amp;
      req_slot_index <= slot;
      req_neighbor_value <= nval;
      req_neighbor_used <= nused;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic end_items();
      req_valid <= 0;
      burst_left = 0;
   endtask

   // Wait until every result is back, then let the block settle.
   task automatic drain();
      end_items();
      @(posedge clock);
      while (board.expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NOISE_WINDOW) board.window = val[7:0];
      else if (idx == CSR_KEEP_FRACTION) board.fraction = val[8:0];
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Nudge a frame around a base so that the merge window edge gets hit.
   function automatic bit [31:0] near_frame(bit [31:0] base);
      return base + $urandom_range(0, 12);
   endfunction

   function automatic bit [15:0] rand_amp();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Build a small cluster: neighbor rows for four channels, spikes, at times an unknown kind, one filter.
   task automatic random_cluster();
      bit [5:0]  chans[4];
      bit [31:0] base;
      int n;
      foreach (chans[i]) chans[i] = 6'($urandom_range(0, 63));
      base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 : $urandom;
      for (int i = 0; i < $urandom_range(0, 3); i++)
         send_item(KIND_LOAD, chans[2'($urandom_range(0, 3))], $urandom,
                   16'($urandom), 3'($urandom), chans[2'($urandom_range(0, 3))],
                   $urandom_range(0, 5) != 0);
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++)
         send_item(KIND_APPEND, chans[2'($urandom_range(0, 3))], near_frame(base),
                   rand_amp(), 3'($urandom), 6'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) == 0)
         send_item(kind_type'(2'd3), 6'($urandom), $urandom, 16'($urandom),
                   3'($urandom), 6'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) == 0)
         send_item(KIND_APPEND, 6'($urandom), $urandom, 16'($urandom),
                   3'($urandom), 6'($urandom), 1'($urandom));
      send_item(KIND_FILTER, chans[2'($urandom_range(0, 3))], base, rand_amp(),
                3'($urandom), 6'($urandom), 1'($urandom));
   endtask

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: filter on empty buffer, table edges, unknown kind, fill past full, filter.
      send_item(KIND_FILTER, 6'd0, 32'hFFFF_FFFF, 16'h8000, 0, 0, 0);
      send_item(KIND_LOAD, 6'd0, 0, 0, 3'd0, 6'd63, 1);
      send_item(KIND_LOAD, 6'd0, 0, 0, 3'd7, 6'd0, 1);
      send_item(KIND_LOAD, 6'd63, 0, 0, 3'd7, 6'd0, 1);
      send_item(KIND_LOAD, 6'd63, 0, 0, 3'd0, 6'd63, 1);
      send_item(KIND_LOAD, 6'd63, 0, 0, 3'd7, 6'd5, 0);
      send_item(kind_type'(2'd3), 6'd63, 32'hFFFF_FFFF, 16'h7FFF, 3'd7, 6'd63, 1);
      // Fill the buffer while the receiver holds off, then overflow.
      hold_off = 1;
      for (int i = 0; i < 66; i++)
         send_item(KIND_APPEND, (i % 2) ? 6'd63 : 6'd0,
                   (i < 3) ? 32'hFFFF_FFFF - i : i, (i % 3) ? 16'h7FFF : 16'h8000,
                   0, 0, 0);
      send_item(KIND_FILTER, 6'd0, 32'hFFFF_FFFA, 16'h8000, 0, 0, 0);
      send_item(KIND_FILTER, 6'd63, 0, 16'h7FFF, 0, 0, 0);
      drain();

      // Random phases over several register settings, extremes included.
      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_NOISE_WINDOW, 0);   write_reg(CSR_KEEP_FRACTION, 0);   end
            1: begin write_reg(CSR_NOISE_WINDOW, 255); write_reg(CSR_KEEP_FRACTION, 256); end
            2: begin write_reg(CSR_NOISE_WINDOW, 3);   write_reg(CSR_KEEP_FRACTION, 511); end
            default: begin
               write_reg(CSR_NOISE_WINDOW, 16'($urandom_range(0, 255)));
               write_reg(CSR_KEEP_FRACTION, 16'($urandom_range(0, 511)));
            end
         endcase
         while (sent < (phase + 1) * 210) begin
            random_cluster();
            sent += 8;
         end
         drain();
      end

      if (board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

@@ files.f @@
rtl/core/snd_pkg.sv
rtl/core/snd_spike_ram.sv
rtl/core/spike_neighbor_dedup.sv
tb/spike_neighbor_dedup_tb.sv
